>>> rtl/mpi_pkg.sv
// Shared types, codes and float helpers for the matrix polynomial iterate unit.
`default_nettype none
package mpi_pkg;

    localparam logic [2:0] MODE_LOAD_A = 3'd0;
    localparam logic [2:0] MODE_LOAD_B = 3'd1;
    localparam logic [2:0] MODE_LOAD_C = 3'd2;
    localparam logic [2:0] MODE_RUN    = 3'd3;
    localparam logic [2:0] MODE_READ   = 3'd4;

    localparam logic KIND_READ = 1'b0;
    localparam logic KIND_DONE = 1'b1;

    localparam logic [31:0] FP_QNAN  = 32'hFFC0_0000;
    localparam logic [31:0] FP_QBIT  = 32'h0040_0000;

    typedef enum logic [3:0] {
        S_CLEAR,
        S_IDLE,
        S_READ,
        S_MRD,
        S_MUL,
        S_MW,
        S_ADD,
        S_AW,
        S_ACC,
        S_ORD,
        S_OADD,
        S_OW,
        S_OWR,
        S_DONE
    } t_state;

    typedef struct packed {
        logic clr;
        logic ld;
        logic out_rd;
        logic out_done;
        logic mac_rd;
        logic acc_upd;
        logic acc_zero;
        logic prod_wr;
        logic add_ofs;
        logic acc_wr;
    } t_cmd;

    function automatic logic [5:0] lzc48(input logic [47:0] v);
        logic [5:0] n;
        logic       found;
        n     = 6'd48;
        found = 1'b0;
        for (int b = 47; b >= 0; b--) begin
            if (!found && v[b]) begin
                n     = 6'(47 - b);
                found = 1'b1;
            end
        end
        return n;
    endfunction

    function automatic logic [4:0] lzc27(input logic [26:0] v);
        logic [4:0] n;
        logic       found;
        n     = 5'd27;
        found = 1'b0;
        for (int b = 26; b >= 0; b--) begin
            if (!found && v[b]) begin
                n     = 5'(26 - b);
                found = 1'b1;
            end
        end
        return n;
    endfunction

endpackage
`default_nettype wire

>>> rtl/mpi_ram.sv
// Generic simple dual-port RAM with registered read.
`default_nettype none
module mpi_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 64
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_we,
    input  wire logic [$clog2(DEPTH)-1:0] i_waddr,
    input  wire logic [WIDTH-1:0]         i_wdata,
    input  wire logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic      [WIDTH-1:0]         o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        o_rdata <= r_mem[i_raddr];
    end
endmodule
`default_nettype wire

>>> rtl/mpi_fmul.sv
// Two-stage single-precision multiplier, round to nearest even.
`default_nettype none
module mpi_fmul (
    input  wire logic        i_clk,
    input  wire logic [31:0] i_a,
    input  wire logic [31:0] i_b,
    output logic      [31:0] o_p
);
    import mpi_pkg::*;

    logic        sa, sb, s;
    logic [7:0]  ea, eb, eaf, ebf;
    logic [22:0] fa, fb;
    logic        a_nan, b_nan, a_inf, b_inf, a_zero, b_zero;
    logic        n_spec;
    logic [31:0] n_sval;

    logic [47:0] r_prod;
    logic signed [10:0] r_exp;
    logic        r_sign, r_spec;
    logic [31:0] r_sval;

    logic [5:0]  lz;
    logic [47:0] pn, q, mask;
    logic signed [10:0] e, sh;
    logic        stk, g, st, rnd, ovf;
    logic [7:0]  field;
    logic [23:0] mant;
    logic [30:0] res;

    always_comb begin
        sa = i_a[31]; ea = i_a[30:23]; fa = i_a[22:0];
        sb = i_b[31]; eb = i_b[30:23]; fb = i_b[22:0];
        s  = sa ^ sb;
        a_nan  = (ea == 8'hFF) && (fa != '0);
        b_nan  = (eb == 8'hFF) && (fb != '0);
        a_inf  = (ea == 8'hFF) && (fa == '0);
        b_inf  = (eb == 8'hFF) && (fb == '0);
        a_zero = (ea == 8'h00) && (fa == '0);
        b_zero = (eb == 8'h00) && (fb == '0);
        eaf = (ea == 8'h00) ? 8'd1 : ea;
        ebf = (eb == 8'h00) ? 8'd1 : eb;
        n_spec = 1'b1;
        if (a_nan) begin
            n_sval = i_a | FP_QBIT;
        end else if (b_nan) begin
            n_sval = i_b | FP_QBIT;
        end else if ((a_inf && b_zero) || (a_zero && b_inf)) begin
            n_sval = FP_QNAN;
        end else if (a_inf || b_inf) begin
            n_sval = {s, 8'hFF, 23'd0};
        end else if (a_zero || b_zero) begin
            n_sval = {s, 31'd0};
        end else begin
            n_spec = 1'b0;
            n_sval = '0;
        end
    end

    always_ff @(posedge i_clk) begin
        r_prod <= {24'd0, (ea != 8'h00), fa} * {24'd0, (eb != 8'h00), fb};
        r_exp  <= $signed(11'(eaf) + 11'(ebf) - 11'd126);
        r_sign <= s;
        r_spec <= n_spec;
        r_sval <= n_sval;
    end

    always_comb begin
        lz  = lzc48(r_prod);
        pn  = r_prod << lz;
        e   = r_exp - $signed(11'(lz));
        sh  = 11'sd1 - e;
        q   = pn;
        stk = 1'b0;
        mask = '0;
        if (e < 11'sd1) begin
            if (sh > 11'sd48) begin
                q   = '0;
                stk = |pn;
            end else begin
                mask = ~({48{1'b1}} << sh[5:0]);
                q    = pn >> sh[5:0];
                stk  = |(pn & mask);
            end
        end
        field = (e < 11'sd1) ? 8'd0 : e[7:0];
        ovf   = e > 11'sd254;
        mant  = q[47:24];
        g     = q[23];
        st    = (|q[22:0]) | stk;
        rnd   = g & (st | mant[0]);
        res   = {field, mant[22:0]} + 31'(rnd);
    end

    always_ff @(posedge i_clk) begin
        if (r_spec) begin
            o_p <= r_sval;
        end else if (ovf) begin
            o_p <= {r_sign, 8'hFF, 23'd0};
        end else begin
            o_p <= {r_sign, res};
        end
    end
endmodule
`default_nettype wire

>>> rtl/mpi_fadd.sv
// Two-stage single-precision adder, round to nearest even.
`default_nettype none
module mpi_fadd (
    input  wire logic        i_clk,
    input  wire logic [31:0] i_a,
    input  wire logic [31:0] i_b,
    output logic      [31:0] o_s
);
    import mpi_pkg::*;

    logic        sa, sb;
    logic [7:0]  ea, eb, eaf, ebf, d;
    logic [22:0] fa, fb;
    logic        a_nan, b_nan, a_inf, b_inf, a_ge;
    logic        n_spec;
    logic [31:0] n_sval;
    logic [23:0] mbig, msml;
    logic [7:0]  ebig, esml;
    logic [26:0] sml27, al, amask;

    logic [26:0] r_big, r_al;
    logic        r_sub, r_sign, r_zs, r_spec;
    logic [7:0]  r_e;
    logic [31:0] r_sval;

    logic [27:0] sum;
    logic [4:0]  lz, lim, sh;
    logic [26:0] n;
    logic [8:0]  e;
    logic [7:0]  field;
    logic        g, st, rnd, ovf;
    logic [30:0] res;

    always_comb begin
        sa = i_a[31]; ea = i_a[30:23]; fa = i_a[22:0];
        sb = i_b[31]; eb = i_b[30:23]; fb = i_b[22:0];
        a_nan = (ea == 8'hFF) && (fa != '0);
        b_nan = (eb == 8'hFF) && (fb != '0);
        a_inf = (ea == 8'hFF) && (fa == '0);
        b_inf = (eb == 8'hFF) && (fb == '0);
        eaf = (ea == 8'h00) ? 8'd1 : ea;
        ebf = (eb == 8'h00) ? 8'd1 : eb;
        n_spec = 1'b1;
        if (a_nan) begin
            n_sval = i_a | FP_QBIT;
        end else if (b_nan) begin
            n_sval = i_b | FP_QBIT;
        end else if (a_inf && b_inf && (sa != sb)) begin
            n_sval = FP_QNAN;
        end else if (a_inf) begin
            n_sval = i_a;
        end else if (b_inf) begin
            n_sval = i_b;
        end else begin
            n_spec = 1'b0;
            n_sval = '0;
        end
        a_ge = i_a[30:0] >= i_b[30:0];
        mbig = a_ge ? {(ea != 8'h00), fa} : {(eb != 8'h00), fb};
        msml = a_ge ? {(eb != 8'h00), fb} : {(ea != 8'h00), fa};
        ebig = a_ge ? eaf : ebf;
        esml = a_ge ? ebf : eaf;
        d    = ebig - esml;
        sml27 = {msml, 3'd0};
        amask = '0;
        if (d >= 8'd27) begin
            al = {26'd0, |msml};
        end else begin
            amask = ~({27{1'b1}} << d[4:0]);
            al    = (sml27 >> d[4:0]) | {26'd0, |(sml27 & amask)};
        end
    end

    always_ff @(posedge i_clk) begin
        r_big  <= {mbig, 3'd0};
        r_al   <= al;
        r_sub  <= sa ^ sb;
        r_sign <= a_ge ? sa : sb;
        r_zs   <= sa & sb;
        r_e    <= ebig;
        r_spec <= n_spec;
        r_sval <= n_sval;
    end

    always_comb begin
        sum = r_sub ? ({1'b0, r_big} - {1'b0, r_al}) : ({1'b0, r_big} + {1'b0, r_al});
        lz  = lzc27(sum[26:0]);
        lim = (r_e > 8'd27) ? 5'd27 : 5'(r_e - 8'd1);
        sh  = (lz < lim) ? lz : lim;
        if (sum[27]) begin
            n = {sum[27:2], sum[1] | sum[0]};
            e = 9'(r_e) + 9'd1;
        end else begin
            n = sum[26:0] << sh;
            e = 9'(r_e) - 9'(sh);
        end
        field = n[26] ? e[7:0] : 8'd0;
        ovf   = e >= 9'd255;
        g     = n[2];
        st    = n[1] | n[0];
        rnd   = g & (st | n[3]);
        res   = {field, n[25:3]} + 31'(rnd);
    end

    always_ff @(posedge i_clk) begin
        if (r_spec) begin
            o_s <= r_sval;
        end else if (sum == '0) begin
            o_s <= {r_zs, 31'd0};
        end else if (ovf) begin
            o_s <= {r_sign, 8'hFF, 23'd0};
        end else begin
            o_s <= {r_sign, res};
        end
    end
endmodule
`default_nettype wire

>>> rtl/mpi_ctrl.sv
// Sequencer for clearing, loads, reads and the matrix iteration loops.
`default_nettype none
module mpi_ctrl #(
    parameter int DIM   = 8,
    parameter int TERMS = 8
) (
    input  wire logic                  i_clk,
    input  wire logic                  i_rst_n,
    input  wire logic                  i_valid,
    input  wire logic [2:0]            i_mode,
    input  wire logic                  i_out_free,
    output logic                       o_ready,
    output mpi_pkg::t_cmd              o_cmd,
    output logic [((TERMS > 1) ? $clog2(TERMS) : 1)-1:0] o_k,
    output logic [$clog2(DIM)-1:0]     o_i,
    output logic [$clog2(DIM)-1:0]     o_j,
    output logic [$clog2(DIM)-1:0]     o_m,
    output logic [$clog2(DIM*DIM)-1:0] o_idx,
    output logic [$clog2(TERMS*DIM*DIM)-1:0] o_clr
);
    import mpi_pkg::*;

    localparam int DW  = $clog2(DIM);
    localparam int TW  = (TERMS > 1) ? $clog2(TERMS) : 1;
    localparam int MW  = DIM * DIM;
    localparam int MAW = $clog2(MW);
    localparam int CAW = $clog2(TERMS * MW);

    t_state r_state, n_state;
    logic [TW-1:0]  r_k, n_k;
    logic [DW-1:0]  r_i, n_i, r_j, n_j, r_m, n_m;
    logic [MAW-1:0] r_idx, n_idx;
    logic [CAW-1:0] r_clr, n_clr;
    logic           accept;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_CLEAR;
            r_k     <= '0;
            r_i     <= '0;
            r_j     <= '0;
            r_m     <= '0;
            r_idx   <= '0;
            r_clr   <= '0;
        end else begin
            r_state <= n_state;
            r_k     <= n_k;
            r_i     <= n_i;
            r_j     <= n_j;
            r_m     <= n_m;
            r_idx   <= n_idx;
            r_clr   <= n_clr;
        end
    end

    always_comb begin
        n_state = r_state;
        n_k     = r_k;
        n_i     = r_i;
        n_j     = r_j;
        n_m     = r_m;
        n_idx   = r_idx;
        n_clr   = r_clr;
        o_cmd   = '0;
        o_ready = (r_state == S_IDLE) && i_out_free;
        accept  = o_ready && i_valid;
        case (r_state)
            S_CLEAR: begin
                o_cmd.clr = 1'b1;
                if (r_clr == CAW'(TERMS * MW - 1)) begin
                    n_state = S_IDLE;
                end else begin
                    n_clr = r_clr + 1'b1;
                end
            end
            S_IDLE: begin
                if (accept) begin
                    o_cmd.ld = 1'b1;
                    if (i_mode == MODE_RUN) begin
                        o_cmd.acc_zero = 1'b1;
                        n_k = '0; n_i = '0; n_j = '0; n_m = '0; n_idx = '0;
                        n_state = S_MRD;
                    end else if (i_mode == MODE_READ) begin
                        n_state = S_READ;
                    end
                end
            end
            S_READ: begin
                o_cmd.out_rd = 1'b1;
                n_state = S_IDLE;
            end
            S_MRD: begin
                o_cmd.mac_rd = 1'b1;
                n_state = S_MUL;
            end
            S_MUL:  n_state = S_MW;
            S_MW:   n_state = S_ADD;
            S_ADD:  n_state = S_AW;
            S_AW:   n_state = S_ACC;
            S_ACC: begin
                n_state = S_MRD;
                if (r_m == DW'(DIM - 1)) begin
                    o_cmd.prod_wr  = 1'b1;
                    o_cmd.acc_zero = 1'b1;
                    n_m = '0;
                    if (r_j == DW'(DIM - 1)) begin
                        n_j = '0;
                        if (r_i == DW'(DIM - 1)) begin
                            n_i = '0;
                            n_state = S_ORD;
                        end else begin
                            n_i = r_i + 1'b1;
                        end
                    end else begin
                        n_j = r_j + 1'b1;
                    end
                end else begin
                    o_cmd.acc_upd = 1'b1;
                    n_m = r_m + 1'b1;
                end
            end
            S_ORD:  n_state = S_OADD;
            S_OADD: begin
                o_cmd.add_ofs = 1'b1;
                n_state = S_OW;
            end
            S_OW: begin
                o_cmd.add_ofs = 1'b1;
                n_state = S_OWR;
            end
            S_OWR: begin
                o_cmd.acc_wr = 1'b1;
                if (r_idx == MAW'(MW - 1)) begin
                    n_idx = '0;
                    if (r_k == TW'(TERMS - 1)) begin
                        n_state = S_DONE;
                    end else begin
                        n_k = r_k + 1'b1;
                        n_state = S_MRD;
                    end
                end else begin
                    n_idx = r_idx + 1'b1;
                    n_state = S_ORD;
                end
            end
            S_DONE: begin
                o_cmd.out_done = 1'b1;
                n_state = S_IDLE;
            end
            default: n_state = S_IDLE;
        endcase
    end

    assign o_k   = r_k;
    assign o_i   = r_i;
    assign o_j   = r_j;
    assign o_m   = r_m;
    assign o_idx = r_idx;
    assign o_clr = r_clr;
endmodule
`default_nettype wire

>>> rtl/mpi_dp.sv
// Datapath: matrix stores, float multiply and add units, accumulator, result register.
`default_nettype none
module mpi_dp #(
    parameter int DIM   = 8,
    parameter int TERMS = 8
) (
    input  wire logic                  i_clk,
    input  wire logic                  i_rst_n,
    input  wire mpi_pkg::t_cmd         i_cmd,
    input  wire logic [((TERMS > 1) ? $clog2(TERMS) : 1)-1:0] i_k,
    input  wire logic [$clog2(DIM)-1:0]     i_i,
    input  wire logic [$clog2(DIM)-1:0]     i_j,
    input  wire logic [$clog2(DIM)-1:0]     i_m,
    input  wire logic [$clog2(DIM*DIM)-1:0] i_idx,
    input  wire logic [$clog2(TERMS*DIM*DIM)-1:0] i_clr,
    input  wire logic [2:0]            i_mode,
    input  wire logic [2:0]            i_term,
    input  wire logic [2:0]            i_row,
    input  wire logic [2:0]            i_col,
    input  wire logic [31:0]           i_value,
    input  wire logic                  i_m_tready,
    output logic                       o_out_free,
    output logic                       o_m_tvalid,
    output logic                       o_kind,
    output logic [31:0]                o_data
);
    import mpi_pkg::*;

    localparam int MW  = DIM * DIM;
    localparam int MAW = $clog2(MW);
    localparam int CD  = TERMS * MW;
    localparam int CAW = $clog2(CD);

    logic [10:0]    pos_full;
    logic [MAW-1:0] pos;
    logic           in_ok, term_ok, clr_small;
    logic [CAW-1:0] c_waddr, c_raddr;
    logic           c_we, o_we, a_we;
    logic [MAW-1:0] o_waddr, a_waddr, a_raddr, p_addr;
    logic [31:0]    a_wdata;
    logic [31:0]    c_rdata, o_rdata, a_rdata, p_rdata;
    logic [31:0]    mul_out, add_out, add_a, add_b;
    logic [31:0]    r_acc;
    logic           r_rd_ok, r_mvalid;

    always_comb begin
        pos_full  = 11'(i_row) * 11'(DIM) + 11'(i_col);
        pos       = pos_full[MAW-1:0];
        in_ok     = (32'(i_row) < DIM) && (32'(i_col) < DIM);
        term_ok   = 32'(i_term) < TERMS;
        clr_small = i_cmd.clr && (32'(i_clr) < MW);

        c_we    = i_cmd.clr || (i_cmd.ld && (i_mode == MODE_LOAD_A) && in_ok && term_ok);
        c_waddr = i_cmd.clr ? i_clr : CAW'(32'(i_term) * MW + 32'(pos));
        c_raddr = CAW'((32'(i_k) * DIM + 32'(i_i)) * DIM + 32'(i_m));

        o_we    = clr_small || (i_cmd.ld && (i_mode == MODE_LOAD_B) && in_ok);
        o_waddr = i_cmd.clr ? i_clr[MAW-1:0] : pos;

        a_we    = clr_small || i_cmd.acc_wr || (i_cmd.ld && (i_mode == MODE_LOAD_C) && in_ok);
        a_waddr = i_cmd.clr ? i_clr[MAW-1:0] : (i_cmd.acc_wr ? i_idx : pos);
        a_wdata = i_cmd.clr ? 32'd0 : (i_cmd.acc_wr ? add_out : i_value);
        a_raddr = i_cmd.mac_rd ? MAW'(32'(i_m) * DIM + 32'(i_j)) : pos;

        p_addr  = MAW'(32'(i_i) * DIM + 32'(i_j));

        add_a = i_cmd.add_ofs ? p_rdata : r_acc;
        add_b = i_cmd.add_ofs ? o_rdata : mul_out;
    end

    mpi_ram #(.WIDTH(32), .DEPTH(CD)) u_coeff (
        .i_clk(i_clk), .i_we(c_we), .i_waddr(c_waddr),
        .i_wdata(i_cmd.clr ? 32'd0 : i_value), .i_raddr(c_raddr), .o_rdata(c_rdata)
    );

    mpi_ram #(.WIDTH(32), .DEPTH(MW)) u_offset (
        .i_clk(i_clk), .i_we(o_we), .i_waddr(o_waddr),
        .i_wdata(i_cmd.clr ? 32'd0 : i_value), .i_raddr(i_idx), .o_rdata(o_rdata)
    );

    mpi_ram #(.WIDTH(32), .DEPTH(MW)) u_accum (
        .i_clk(i_clk), .i_we(a_we), .i_waddr(a_waddr),
        .i_wdata(a_wdata), .i_raddr(a_raddr), .o_rdata(a_rdata)
    );

    mpi_ram #(.WIDTH(32), .DEPTH(MW)) u_product (
        .i_clk(i_clk), .i_we(i_cmd.prod_wr), .i_waddr(p_addr),
        .i_wdata(add_out), .i_raddr(i_idx), .o_rdata(p_rdata)
    );

    mpi_fmul u_fmul (.i_clk(i_clk), .i_a(c_rdata), .i_b(a_rdata), .o_p(mul_out));
    mpi_fadd u_fadd (.i_clk(i_clk), .i_a(add_a), .i_b(add_b), .o_s(add_out));

    always_ff @(posedge i_clk) begin
        if (i_cmd.acc_zero) begin
            r_acc <= '0;
        end else if (i_cmd.acc_upd) begin
            r_acc <= add_out;
        end
        if (i_cmd.ld) begin
            r_rd_ok <= in_ok;
        end
        if (i_cmd.out_rd) begin
            o_kind <= KIND_READ;
            o_data <= r_rd_ok ? a_rdata : 32'd0;
        end else if (i_cmd.out_done) begin
            o_kind <= KIND_DONE;
            o_data <= 32'd0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mvalid <= 1'b0;
        end else if (i_cmd.out_rd || i_cmd.out_done) begin
            r_mvalid <= 1'b1;
        end else if (i_m_tready) begin
            r_mvalid <= 1'b0;
        end
    end

    assign o_m_tvalid = r_mvalid;
    assign o_out_free = !r_mvalid || i_m_tready;
endmodule
`default_nettype wire

>>> rtl/matrix_polynomial_iterate_unit.sv
// Top level of the matrix polynomial iterate unit.
// Holds TERMS coefficient matrices A_k, an offset B and an accumulator C, each DIM x DIM
// single-precision, and on a run applies C := A_k*C + B for k ascending, every multiply
// and add rounded to nearest even. A read returns its element through the S_READ state
// and the output register. A run is worked one multiply-add at a time by one shared
// multiplier and one shared adder, each two stages deep. After reset a clearing pass
// zeroes the coefficient, offset and accumulator stores before the first item is taken.
`default_nettype none
module matrix_polynomial_iterate_unit #(
    parameter int DIM   = 8,
    parameter int TERMS = 8
) (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        s_axis_tvalid,
    output logic             s_axis_tready,
    input  wire logic [47:0] s_axis_tdata,  // term[2:0], row[5:3], col[8:6], value[40:9]
    input  wire logic [2:0]  s_axis_tuser,  // mode[2:0]
    output logic             m_axis_tvalid,
    input  wire logic        m_axis_tready,
    output logic [31:0]      m_axis_tdata,  // data[31:0]
    output logic [0:0]       m_axis_tuser   // kind[0]
);
    import mpi_pkg::*;

    localparam int DW  = $clog2(DIM);
    localparam int TW  = (TERMS > 1) ? $clog2(TERMS) : 1;
    localparam int MAW = $clog2(DIM * DIM);
    localparam int CAW = $clog2(TERMS * DIM * DIM);

    t_cmd           cmd;
    logic           out_free;
    logic [TW-1:0]  k;
    logic [DW-1:0]  i, j, m;
    logic [MAW-1:0] idx;
    logic [CAW-1:0] clr;

    mpi_ctrl #(.DIM(DIM), .TERMS(TERMS)) u_ctrl (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_valid(s_axis_tvalid), .i_mode(s_axis_tuser), .i_out_free(out_free),
        .o_ready(s_axis_tready), .o_cmd(cmd),
        .o_k(k), .o_i(i), .o_j(j), .o_m(m), .o_idx(idx), .o_clr(clr)
    );

    mpi_dp #(.DIM(DIM), .TERMS(TERMS)) u_dp (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_cmd(cmd),
        .i_k(k), .i_i(i), .i_j(j), .i_m(m), .i_idx(idx), .i_clr(clr),
        .i_mode(s_axis_tuser), .i_term(s_axis_tdata[2:0]), .i_row(s_axis_tdata[5:3]),
        .i_col(s_axis_tdata[8:6]), .i_value(s_axis_tdata[40:9]),
        .i_m_tready(m_axis_tready), .o_out_free(out_free),
        .o_m_tvalid(m_axis_tvalid), .o_kind(m_axis_tuser[0]), .o_data(m_axis_tdata)
    );
endmodule
`default_nettype wire
